@@ hdl/espe_pkg.sv @@
package espe_pkg;

    localparam int PROFILE_MAX      = 16;
    localparam int PROFILE_COUNT_DF = 12;
    localparam int TIMER_TOP_DF     = 65535;

    localparam int CNT_W    = 16;
    localparam int SEL_W    = 4;
    localparam int MASK_W   = 12;
    localparam int PERIOD_W = 16;
    localparam int RPM_W    = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [MASK_W-1:0]   MASK_RST   = 12'd4095;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_MASK   = 1'b0,
        REG_CHANGE_PERIOD = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] high_reload;
        logic [CNT_W-1:0] low_reload;
        logic [RPM_W-1:0] rpm;
    } rpm_entry_t;

    typedef struct packed {
        logic level;
        logic edge_driven;
    } timer_status_t;

    function automatic rpm_entry_t profile_rom(input logic [SEL_W-1:0] idx);
        rpm_entry_t e;
        case (idx)
            4'd0:    e = '{16'd61473, 16'd3135,  14'd650};
            4'd1:    e = '{16'd62235, 16'd14835, 14'd800};
            4'd2:    e = '{16'd62895, 16'd24975, 14'd1000};
            4'd3:    e = '{16'd64215, 16'd45255, 14'd2000};
            4'd4:    e = '{16'd64655, 16'd52015, 14'd3000};
            4'd5:    e = '{16'd64875, 16'd55395, 14'd4000};
            4'd6:    e = '{16'd65007, 16'd57423, 14'd5000};
            4'd7:    e = '{16'd65095, 16'd58775, 14'd6000};
            4'd8:    e = '{16'd65158, 16'd59741, 14'd7000};
            4'd9:    e = '{16'd65205, 16'd60465, 14'd8000};
            4'd10:   e = '{16'd65242, 16'd61028, 14'd9000};
            4'd11:   e = '{16'd65271, 16'd61479, 14'd10000};
            default: e = '{16'd0, 16'd0, 14'd0};
        endcase
        return e;
    endfunction

    // index of the pos-th set bit, zero if there is none
    function automatic logic [SEL_W-1:0] nth_active(input logic [PROFILE_MAX-1:0] mask,
                                                   input logic [SEL_W-1:0] pos);
        logic [SEL_W-1:0]       res;
        logic [PROFILE_MAX-1:0] below;
        logic [SEL_W:0]         cnt;
        res = '0;
        for (int j = 0; j < PROFILE_MAX; j++)
        begin
            below = mask & ((PROFILE_MAX'(1) << j) - PROFILE_MAX'(1));
            cnt   = (SEL_W+1)'($countones(below));
            if (mask[j] && cnt == {1'b0, pos})
            begin
                res = SEL_W'(j);
            end
        end
        return res;
    endfunction

endpackage

@@ hdl/espe_timer.sv @@
module espe_timer #(
    parameter int TIMER_TOP = espe_pkg::TIMER_TOP_DF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        pulse_tick,
    input  logic [espe_pkg::SEL_W-1:0]  profile_sel,
    input  logic [espe_pkg::PROFILE_MAX-1:0] en_mask,
    output espe_pkg::timer_status_t     status
);
    import espe_pkg::*;

    localparam logic [CNT_W-1:0] TOP = CNT_W'(TIMER_TOP);

    logic [CNT_W-1:0] pulse_counter_reg, pulse_counter_next;
    logic             high_next_reg, high_next_next;
    logic             level_reg, level_next;
    logic             edge_next;
    rpm_entry_t       entry;

    assign entry = profile_rom(profile_sel);

    always_comb
    begin
        pulse_counter_next = pulse_counter_reg;
        high_next_next     = high_next_reg;
        level_next         = level_reg;
        edge_next          = 1'b0;
        if (pulse_tick)
        begin
            if (pulse_counter_reg >= TOP)
            begin
                if (en_mask[profile_sel])
                begin
                    edge_next      = 1'b1;
                    level_next     = high_next_reg;
                    high_next_next = ~high_next_reg;
                    pulse_counter_next = high_next_reg ? entry.high_reload : entry.low_reload;
                end
                else
                begin
                    pulse_counter_next = '0;
                end
            end
            else
            begin
                pulse_counter_next = pulse_counter_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_counter_reg <= '0;
            high_next_reg     <= 1'b1;
            level_reg         <= 1'b0;
        end
        else if (accept)
        begin
            pulse_counter_reg <= pulse_counter_next;
            high_next_reg     <= high_next_next;
            level_reg         <= level_next;
        end
    end

    assign status.level       = level_next;
    assign status.edge_driven = edge_next;

endmodule

@@ hdl/espe_profile.sv @@
module espe_profile (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            ms_tick,
    input  logic [espe_pkg::PERIOD_W-1:0]   change_period,
    input  logic [espe_pkg::PROFILE_MAX-1:0] en_mask,
    output logic [espe_pkg::SEL_W-1:0]      sel_cur,
    output logic [espe_pkg::SEL_W-1:0]      sel_next
);
    import espe_pkg::*;

    logic [PERIOD_W-1:0] ms_count_reg, ms_count_next;
    logic [SEL_W-1:0]    profile_sel_reg, profile_sel_next;
    logic [SEL_W-1:0]    list_position_reg, list_position_next;
    logic [PERIOD_W:0]   ms_inc;
    logic [SEL_W:0]      list_len;

    assign ms_inc   = {1'b0, ms_count_reg} + (PERIOD_W+1)'(1);
    assign list_len = (SEL_W+1)'($countones(en_mask));

    always_comb
    begin
        ms_count_next      = ms_count_reg;
        profile_sel_next   = profile_sel_reg;
        list_position_next = list_position_reg;
        if (ms_tick)
        begin
            if (ms_inc >= {1'b0, change_period})
            begin
                ms_count_next = '0;
                if ({1'b0, list_position_reg} < list_len)
                begin
                    profile_sel_next   = nth_active(en_mask, list_position_reg);
                    list_position_next = list_position_reg + SEL_W'(1);
                end
                else
                begin
                    list_position_next = '0;
                end
            end
            else
            begin
                ms_count_next = ms_inc[PERIOD_W-1:0];
            end
        end
    end

    // reset mask has every entry active, so the walk starts at entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_count_reg      <= '0;
            profile_sel_reg   <= '0;
            list_position_reg <= SEL_W'(1);
        end
        else if (accept)
        begin
            ms_count_reg      <= ms_count_next;
            profile_sel_reg   <= profile_sel_next;
            list_position_reg <= list_position_next;
        end
    end

    assign sel_cur  = profile_sel_reg;
    assign sel_next = profile_sel_next;

endmodule

@@ hdl/engine_speed_pulse_emulator_core.sv @@
// the result word is registered and is shown on the master side in the cycle after its input word is accepted
// throughput: one word per cycle, the output register frees as its word is taken
// config writes are registered, cfg_ready is always high
// reset (rst_n, async, active low): counter 0, level low, first overflow drives high,
// profile 0, all twelve entries active, change period 5000 ms
module engine_speed_pulse_emulator_core #(
    parameter int PROFILE_COUNT = espe_pkg::PROFILE_COUNT_DF,
    parameter int TIMER_TOP     = espe_pkg::TIMER_TOP_DF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [espe_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // pulse_tick, ms_tick
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [espe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // out_level, edge_driven, current_profile[3:0], engine_rpm[13:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [espe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [espe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import espe_pkg::*;

    localparam logic [PROFILE_MAX-1:0] PC_MASK =
        PROFILE_MAX'((33'd1 << PROFILE_COUNT) - 33'd1);

    logic [MASK_W-1:0]      active_mask_reg;
    logic [PERIOD_W-1:0]    change_period_reg;
    logic [PROFILE_MAX-1:0] en_mask;
    logic                   accept;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [SEL_W-1:0]       sel_cur, sel_next;
    logic [RPM_W-1:0]       rpm_next;
    timer_status_t          tstat;
    rpm_entry_t             entry_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mask_reg   <= MASK_RST;
            change_period_reg <= PERIOD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ACTIVE_MASK:   active_mask_reg   <= cfg_data[MASK_W-1:0];
                REG_CHANGE_PERIOD: change_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign en_mask       = PROFILE_MAX'(active_mask_reg) & PC_MASK;
    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;

    espe_timer #(
        .TIMER_TOP (TIMER_TOP)
    ) u_timer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pulse_tick  (s_axis_tdata[0]),
        .profile_sel (sel_cur),
        .en_mask     (en_mask),
        .status      (tstat)
    );

    espe_profile u_profile (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .ms_tick       (s_axis_tdata[1]),
        .change_period (change_period_reg),
        .en_mask       (en_mask),
        .sel_cur       (sel_cur),
        .sel_next      (sel_next)
    );

    assign entry_next    = profile_rom(sel_next);
    assign rpm_next      = PC_MASK[sel_next] ? entry_next.rpm : '0;
    assign out_data_next = OUT_TDATA_W'({rpm_next, sel_next, tstat.edge_driven, tstat.level});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ hdl/espe_checker.sv @@
module espe_checker #(
    parameter int PROFILE_COUNT = espe_pkg::PROFILE_COUNT_DF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [espe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import espe_pkg::*;

    // a result word only appears after an input word was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result word without accepted input word");

    // a new input word can be taken whenever the result side drains
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side is ready");

    // profiles inside the rom carry a nonzero rpm, others read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((32'(m_axis_tdata[5:2]) < PROFILE_COUNT) == (m_axis_tdata[19:6] != '0)))
        else $error("rpm does not match profile index");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

endmodule

bind engine_speed_pulse_emulator_core espe_checker #(
    .PROFILE_COUNT (PROFILE_COUNT)
) u_espe_checker (.*);
